// File: rtl/core/rlts_pkg.sv
// ----------------------------------------------------------------------------
// rlts_pkg: shared definitions for the random labelled tree sampler
// Field widths, the epoch tag used to invalidate the vertex order memory,
// the controller state type and the edge record passed to the output stage.
// ----------------------------------------------------------------------------
package rlts_pkg;

  localparam int MAX_VERTICES_DEF = 1024;

  // Fixed widths of the stream fields and of the vertex count register.
  localparam int FIELD_W = 10;
  localparam int CFG_W   = 11;
  localparam int TDATA_W = 24;

  // Every tree gets a fresh epoch; a memory word whose tag differs from the
  // current epoch reads as the identity entry.  Tag zero is never current
  // while a tree is built.
  localparam int                 EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FETCH,
    ST_SWAP
  } rlts_state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] edge_from;
    logic [FIELD_W-1:0] edge_to;
    logic               last_edge;
  } rlts_edge_t;

endpackage

// File: rtl/core/rlts_order_mem.sv
// ----------------------------------------------------------------------------
// rlts_order_mem: vertex order store
// One write port and two read ports, read data registered.
// A read at the address written in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module rlts_order_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int WORD_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WORD_W-1:0] rdata0,
  output logic [WORD_W-1:0] rdata1
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: rtl/core/rlts_walk_ctrl.sv
// ----------------------------------------------------------------------------
// rlts_walk_ctrl: loop-erased walk sequencer
// Clamps the draws, reads the order memory, swaps the chosen slot into the
// step position and hands one edge per non-root step to the output stage.
// ----------------------------------------------------------------------------
module rlts_walk_ctrl #(
  parameter int MAX_VERTICES = 1024,
  parameter int ADDR_W       = 10,
  parameter int CNT_W        = 11
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [CNT_W-1:0]                         n_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [rlts_pkg::FIELD_W-1:0]             draw_any_i,
  input  logic [rlts_pkg::FIELD_W-1:0]             draw_unvisited_i,
  input  logic                                     res_ready_i,
  output logic                                     res_valid_o,
  output rlts_pkg::rlts_edge_t                     res_o,
  output logic                                     mem_we_o,
  output logic [ADDR_W-1:0]                        mem_waddr_o,
  output logic [rlts_pkg::EPOCH_W+ADDR_W-1:0]      mem_wdata_o,
  output logic [ADDR_W-1:0]                        mem_raddr0_o,
  output logic [ADDR_W-1:0]                        mem_raddr1_o,
  input  logic [rlts_pkg::EPOCH_W+ADDR_W-1:0]      mem_rdata0_i,
  input  logic [rlts_pkg::EPOCH_W+ADDR_W-1:0]      mem_rdata1_i
);
  import rlts_pkg::*;

  localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  rlts_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [ADDR_W-1:0]   walk_r, walk_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]   a_r, a_nxt;
  logic [ADDR_W-1:0]   b_r, b_nxt;
  logic [ADDR_W-1:0]   k_r, k_nxt;
  logic                start_r, start_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [ADDR_W-1:0]   oldk_r, oldk_nxt;
  logic [ADDR_W-1:0]   newk_r, newk_nxt;
  logic [ADDR_W-1:0]   rq0_r, rq0_nxt;
  logic [ADDR_W-1:0]   rq1_r, rq1_nxt;
  logic                fwd0_r, fwd0_nxt;
  logic                fwd1_r, fwd1_nxt;
  logic [ADDR_W-1:0]   fdata_r, fdata_nxt;

  logic [CNT_W-1:0]    k1;
  logic [CNT_W-1:0]    step_after;
  logic                last_c;
  logic                finishing;
  logic [CNT_W-1:0]    step_cur;
  logic                start_c;
  logic                need_clear;
  logic                accept;
  logic [CMP_W-1:0]    nm1, a_ext, b_ext, k_ext, a_cl, b_lo, b_cl;
  logic [ADDR_W-1:0]   a_c, b_c, k_c;
  logic [ADDR_W-1:0]   d0, d1;

  // Decode the registered read words: a stale tag means the identity entry.
  assign d0 = fwd0_r ? fdata_r :
              (mem_rdata0_i[EPOCH_W+ADDR_W-1:ADDR_W] == epoch_r) ?
              mem_rdata0_i[ADDR_W-1:0] : rq0_r;
  assign d1 = fwd1_r ? fdata_r :
              (mem_rdata1_i[EPOCH_W+ADDR_W-1:ADDR_W] == epoch_r) ?
              mem_rdata1_i[ADDR_W-1:0] : rq1_r;

  assign k1         = CNT_W'(k_r) + CNT_W'(1);
  assign last_c     = !start_r && (k1 >= n_i);
  assign step_after = start_r ? CNT_W'(1) : (last_c ? '0 : k1);
  assign finishing  = (state_r == ST_SWAP) && (start_r || res_ready_i);
  assign step_cur   = finishing ? step_after : step_r;
  assign start_c    = (step_cur == '0) || (step_cur >= n_i);
  assign need_clear = start_c && (epoch_r == EPOCH_MAX);
  assign in_ready_o = ((state_r == ST_IDLE) || finishing) && !need_clear;
  assign accept     = in_valid_i && in_ready_o;

  // Draw clamping against the vertex count and the step index.
  assign nm1   = CMP_W'(n_i) - CMP_W'(1);
  assign a_ext = CMP_W'(draw_any_i);
  assign b_ext = CMP_W'(draw_unvisited_i);
  assign k_ext = CMP_W'(step_cur);
  assign a_cl  = (a_ext > nm1) ? nm1 : a_ext;
  assign b_lo  = (b_ext < k_ext) ? k_ext : b_ext;
  assign b_cl  = (b_lo > nm1) ? nm1 : b_lo;
  assign a_c   = ADDR_W'(a_cl);
  assign b_c   = ADDR_W'(b_cl);
  assign k_c   = ADDR_W'(step_cur);

  assign res_valid_o     = finishing && !start_r;
  assign res_o.edge_from = FIELD_W'(walk_r);
  assign res_o.edge_to   = FIELD_W'(newk_r);
  assign res_o.last_edge = last_c;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    walk_nxt     = walk_r;
    epoch_nxt    = epoch_r;
    clr_addr_nxt = clr_addr_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    start_nxt    = start_r;
    slot_nxt     = slot_r;
    oldk_nxt     = oldk_r;
    newk_nxt     = newk_r;
    rq0_nxt      = rq0_r;
    rq1_nxt      = rq1_r;
    // Forwarding only ever covers the reads issued at the accepting edge.
    fwd0_nxt     = 1'b0;
    fwd1_nxt     = 1'b0;
    fdata_nxt    = fdata_r;
    mem_we_o     = 1'b0;
    mem_waddr_o  = slot_r;
    mem_wdata_o  = {epoch_r, oldk_r};
    mem_raddr0_o = a_c;
    mem_raddr1_o = k_c;

    case (state_r)
      ST_CLEAR: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = clr_addr_r;
        mem_wdata_o  = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(MAX_VERTICES - 1)) begin
          clr_addr_nxt = '0;
          epoch_nxt    = '0;
          step_nxt     = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (need_clear) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_LOOK: begin
        if (start_r) begin
          // Root: slot 0 takes the root, the root's slot takes vertex 0.
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          mem_wdata_o = {epoch_r, a_r};
          slot_nxt    = a_r;
          oldk_nxt    = '0;
          newk_nxt    = a_r;
          walk_nxt    = a_r;
          state_nxt   = ST_SWAP;
        end else if (a_r < k_r) begin
          // Visited vertex: the walk moves there, then the second draw.
          walk_nxt     = d0;
          oldk_nxt     = d1;
          slot_nxt     = b_r;
          mem_raddr0_o = b_r;
          rq0_nxt      = b_r;
          fwd0_nxt     = 1'b0;
          state_nxt    = ST_FETCH;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = k_r;
          mem_wdata_o = {epoch_r, d0};
          newk_nxt    = d0;
          oldk_nxt    = d1;
          slot_nxt    = a_r;
          state_nxt   = ST_SWAP;
        end
      end
      ST_FETCH: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_r;
        mem_wdata_o = {epoch_r, d0};
        newk_nxt    = d0;
        state_nxt   = ST_SWAP;
      end
      ST_SWAP: begin
        mem_we_o = 1'b1;
        if (finishing) begin
          step_nxt = step_after;
          if (!start_r) begin
            walk_nxt = newk_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (accept) begin
      a_nxt     = a_c;
      b_nxt     = b_c;
      k_nxt     = k_c;
      start_nxt = start_c;
      rq0_nxt   = a_c;
      rq1_nxt   = k_c;
      // The swap write of this cycle lands after the reads: forward it.
      fwd0_nxt  = (state_r == ST_SWAP) && (a_c == slot_r);
      fwd1_nxt  = (state_r == ST_SWAP) && (k_c == slot_r);
      fdata_nxt = oldk_r;
      if (start_c) begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
      state_nxt = ST_LOOK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      step_r     <= '0;
      walk_r     <= '0;
      epoch_r    <= '0;
      clr_addr_r <= '0;
      start_r    <= 1'b0;
      fwd0_r     <= 1'b0;
      fwd1_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      walk_r     <= walk_nxt;
      epoch_r    <= epoch_nxt;
      clr_addr_r <= clr_addr_nxt;
      start_r    <= start_nxt;
      fwd0_r     <= fwd0_nxt;
      fwd1_r     <= fwd1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    slot_r  <= slot_nxt;
    oldk_r  <= oldk_nxt;
    newk_r  <= newk_nxt;
    rq0_r   <= rq0_nxt;
    rq1_r   <= rq1_nxt;
    fdata_r <= fdata_nxt;
  end

  // The second draw is only fetched after a first look at the memory.
  a_fetch_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH |-> $past(state_r) == ST_LOOK)
    else $error("fetch state entered without a preceding look");

  // A walk step always runs under a live epoch, never the cleared tag.
  a_live_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !start_c |-> epoch_r != '0)
    else $error("walk step accepted under the cleared epoch");

  // The closing edge of a tree returns the step index to zero.
  a_last_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_o && res_o.last_edge |=> step_r == '0)
    else $error("step index not cleared after the last edge");

  // A forwarded read always stems from a write in the previous cycle.
  a_forward_source: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd0_r || fwd1_r) |-> $past(mem_we_o) && $past(state_r) == ST_SWAP)
    else $error("forwarding without a matching swap write");

endmodule

// File: rtl/core/random_labelled_tree_sampler_top.sv
// ----------------------------------------------------------------------------
// random_labelled_tree_sampler_top: uniform random labelled tree sampler
// Builds random spanning trees of the complete graph by loop-erased walks,
// one edge per non-root input word, using externally supplied random draws.
// ----------------------------------------------------------------------------
// Usage.  Each input word carries two random draws.  The first word of a tree
// picks the root and yields no output; each of the following n-1 words yields
// one edge (parent, child) on the output stream, and the tree's last edge is
// flagged with out_tlast.  The next input word then starts a new tree.
// The user writes the vertex count n via cfg_wr_en/cfg_wr_data only while the
// block is idle, unchecked by it; values outside 2..MAX_VERTICES are clamped.
// Sequence.  A word whose first draw lands on an unvisited vertex passes
// through the look and swap states; one whose first draw lands on a visited
// vertex passes through look, fetch and swap, since the order memory must
// then be read a second time before the swap.  The root word passes through
// look and swap.  The edge enters the output register at the end of the swap,
// and the next input word is taken in that same cycle unless a sweep is due.
// Reset.  After rst_n the order memory is swept, one entry a cycle, over all
// MAX_VERTICES entries with in_tready low; the same sweep precedes a new tree
// once every 255 trees, when the epoch tags run out.
// Stalls.  The output register holds one edge; while it is not taken, the
// block carries each edge word up to the swap, holds it there and keeps
// in_tready low.
// ----------------------------------------------------------------------------
module random_labelled_tree_sampler_top #(
  parameter int MAX_VERTICES = rlts_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: draw_any [9:0], draw_unvisited [19:10], zero padding above.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rlts_pkg::TDATA_W-1:0]     in_tdata,
  // out_tdata: edge_from [9:0], edge_to [19:10], zero padding above.
  // out_tlast: last_edge.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rlts_pkg::TDATA_W-1:0]     out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [rlts_pkg::CFG_W-1:0]       cfg_wr_data
);
  import rlts_pkg::*;

  localparam int ADDR_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WORD_W = EPOCH_W + ADDR_W;

  logic [CFG_W-1:0]   vcount_r, vcount_nxt;
  logic [LIM_W-1:0]   vcount_ext, n_lim;
  logic [CNT_W-1:0]   n_eff;

  logic               out_valid_r, out_valid_nxt;
  rlts_edge_t         out_edge_r, out_edge_nxt;

  logic               res_ready;
  logic               res_valid;
  rlts_edge_t         res;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr0, mem_raddr1;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata0, mem_rdata1;

  // Vertex count register, clamped into the supported range.
  assign vcount_nxt = cfg_wr_en ? cfg_wr_data : vcount_r;
  assign vcount_ext = LIM_W'(vcount_r);
  assign n_lim      = (vcount_ext < LIM_W'(2)) ? LIM_W'(2) :
                      (vcount_ext > LIM_W'(MAX_VERTICES)) ? LIM_W'(MAX_VERTICES) :
                      vcount_ext;
  assign n_eff      = CNT_W'(n_lim);

  // The output register is free when empty or drained in this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_edge_nxt  = out_edge_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_edge_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= CFG_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_edge_r <= out_edge_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - 2 * FIELD_W){1'b0}},
                       out_edge_r.edge_to, out_edge_r.edge_from};
  assign out_tlast  = out_edge_r.last_edge;

  rlts_walk_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .ADDR_W       (ADDR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .n_i              (n_eff),
    .in_valid_i       (in_tvalid),
    .in_ready_o       (in_tready),
    .draw_any_i       (in_tdata[FIELD_W-1:0]),
    .draw_unvisited_i (in_tdata[2*FIELD_W-1:FIELD_W]),
    .res_ready_i      (res_ready),
    .res_valid_o      (res_valid),
    .res_o            (res),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr0_o     (mem_raddr0),
    .mem_raddr1_o     (mem_raddr1),
    .mem_rdata0_i     (mem_rdata0),
    .mem_rdata1_i     (mem_rdata1)
  );

  rlts_order_mem #(
    .DEPTH  (MAX_VERTICES),
    .ADDR_W (ADDR_W),
    .WORD_W (WORD_W)
  ) u_order_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

endmodule
